FILE: sv/rmq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types, constants and width helpers for the matrix to quaternion core.
// ----------------------------------------------------------------------------
package rmq_pkg;

    localparam int FRAC_BITS_DEF = 14;
    localparam int N_COMP        = 4;
    localparam int IN_W          = 16;
    localparam int OUT_W         = 16;
    localparam int FIFO_DEPTH    = 4;

    // component positions inside a quaternion lane vector
    localparam int IDX_W = 0;
    localparam int IDX_X = 1;
    localparam int IDX_Y = 2;
    localparam int IDX_Z = 3;

    typedef struct packed {
        logic signed [IN_W-1:0] m00;
        logic signed [IN_W-1:0] m01;
        logic signed [IN_W-1:0] m02;
        logic signed [IN_W-1:0] m10;
        logic signed [IN_W-1:0] m11;
        logic signed [IN_W-1:0] m12;
        logic signed [IN_W-1:0] m20;
        logic signed [IN_W-1:0] m21;
        logic signed [IN_W-1:0] m22;
    } t_mat_in;

    typedef struct packed {
        logic signed [OUT_W-1:0] quat_w;
        logic signed [OUT_W-1:0] quat_x;
        logic signed [OUT_W-1:0] quat_y;
        logic signed [OUT_W-1:0] quat_z;
    } t_quat_out;

    typedef struct packed {
        logic front_vld;
        logic fifo_full;
        logic fifo_empty;
    } t_stat;

    // width of a clamped diagonal sum: three Q2.14 terms plus one
    function automatic int s_width(input int frac);
        return ((frac > 17) ? frac : 17) + 1;
    endfunction

    // even radicand width for sqrt(S << frac)
    function automatic int rad_width(input int frac);
        return s_width(frac) + frac + ((s_width(frac) + frac) % 2);
    endfunction

endpackage

FILE: sv/rmq_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_front
// Forms the four clamped diagonal sums, picks the leading component and
// derives the component signs.
// ----------------------------------------------------------------------------
module rmq_front #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  rmq_pkg::t_mat_in     i_mat,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [rmq_pkg::N_COMP*rmq_pkg::s_width(FRAC_BITS)+rmq_pkg::N_COMP-1:0] o_data
);
    localparam int SW = rmq_pkg::s_width(FRAC_BITS);
    localparam int QL = rmq_pkg::N_COMP;
    localparam int IN_W_P = rmq_pkg::IN_W;
    localparam logic signed [SW:0] ONE = (SW+1)'(1) << FRAC_BITS;

    typedef enum logic [1:0] {LEAD_W, LEAD_X, LEAD_Y, LEAD_Z} t_lead;

    logic signed [SW:0]      e00, e11, e22;
    logic signed [SW:0]      t [QL];
    logic [SW-1:0]           c [QL];
    logic [1:0]              k;
    t_lead                   lead;
    logic signed [IN_W_P:0]  d_zy, d_xz, d_yx, p_xy, p_zx, p_yz;
    logic [QL-1:0]           neg;

    logic                    r_vld;
    logic [SW-1:0]           r_s [QL];
    logic [QL-1:0]           r_neg;

    assign e00 = (SW+1)'(i_mat.m00);
    assign e11 = (SW+1)'(i_mat.m11);
    assign e22 = (SW+1)'(i_mat.m22);

    assign t[rmq_pkg::IDX_W] =  e00 + e11 + e22 + ONE;
    assign t[rmq_pkg::IDX_X] =  e00 - e11 - e22 + ONE;
    assign t[rmq_pkg::IDX_Y] = -e00 + e11 - e22 + ONE;
    assign t[rmq_pkg::IDX_Z] = -e00 - e11 + e22 + ONE;

    always_comb begin
        for (int i = 0; i < QL; i++) begin
            c[i] = t[i][SW] ? '0 : t[i][SW-1:0];
        end
        // strict compare keeps ties on the earlier component
        k = 2'd0;
        for (int i = 1; i < QL; i++) begin
            if (c[i] > c[k]) begin
                k = 2'(i);
            end
        end
    end

    assign lead = t_lead'(k);

    assign d_zy = (IN_W_P+1)'(i_mat.m21) - (IN_W_P+1)'(i_mat.m12);
    assign d_xz = (IN_W_P+1)'(i_mat.m02) - (IN_W_P+1)'(i_mat.m20);
    assign d_yx = (IN_W_P+1)'(i_mat.m10) - (IN_W_P+1)'(i_mat.m01);
    assign p_xy = (IN_W_P+1)'(i_mat.m10) + (IN_W_P+1)'(i_mat.m01);
    assign p_zx = (IN_W_P+1)'(i_mat.m02) + (IN_W_P+1)'(i_mat.m20);
    assign p_yz = (IN_W_P+1)'(i_mat.m21) + (IN_W_P+1)'(i_mat.m12);

    // w sign is flipped at the end, so w is negative unless its source is negative
    always_comb begin
        neg = '0;
        unique case (lead)
            LEAD_W: begin
                neg[rmq_pkg::IDX_W] = 1'b1;
                neg[rmq_pkg::IDX_X] = d_zy[IN_W_P];
                neg[rmq_pkg::IDX_Y] = d_xz[IN_W_P];
                neg[rmq_pkg::IDX_Z] = d_yx[IN_W_P];
            end
            LEAD_X: begin
                neg[rmq_pkg::IDX_W] = !d_zy[IN_W_P];
                neg[rmq_pkg::IDX_Y] = p_xy[IN_W_P];
                neg[rmq_pkg::IDX_Z] = p_zx[IN_W_P];
            end
            LEAD_Y: begin
                neg[rmq_pkg::IDX_W] = !d_xz[IN_W_P];
                neg[rmq_pkg::IDX_X] = p_xy[IN_W_P];
                neg[rmq_pkg::IDX_Z] = p_yz[IN_W_P];
            end
            LEAD_Z: begin
                neg[rmq_pkg::IDX_W] = !d_yx[IN_W_P];
                neg[rmq_pkg::IDX_X] = p_zx[IN_W_P];
                neg[rmq_pkg::IDX_Y] = p_yz[IN_W_P];
            end
            default: neg = '0;
        endcase
    end

    assign o_ready = !r_vld || i_ready;
    assign o_valid = r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_s   <= c;
            r_neg <= neg;
        end
    end

    always_comb begin
        o_data[QL-1:0] = r_neg;
        for (int i = 0; i < QL; i++) begin
            o_data[QL + i*SW +: SW] = r_s[i];
        end
    end

endmodule

FILE: sv/rmq_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_fifo
// Short word queue between the front and back parts.
// ----------------------------------------------------------------------------
module rmq_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = rmq_pkg::FIFO_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_full,
    output logic         o_empty
);
    localparam int PW = $clog2(DEPTH);

    logic [W-1:0] r_mem [DEPTH];
    logic [PW:0]  r_wp, r_rp;
    logic         push_ok, pop_ok;

    assign o_empty = (r_wp == r_rp);
    assign o_full  = (r_wp[PW] != r_rp[PW]) && (r_wp[PW-1:0] == r_rp[PW-1:0]);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp[PW-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            if (push_ok) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop_ok) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wp[PW-1:0]] <= i_data;
        end
    end

endmodule

FILE: sv/rmq_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_isqrt
// Pipelined integer square root, one root bit per stage, several lanes.
// ----------------------------------------------------------------------------
module rmq_isqrt #(
    parameter int RW    = 32,
    parameter int LANES = 1,
    parameter int SBW   = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  logic [RW-1:0]   i_rad [LANES],
    input  logic [SBW-1:0]  i_sb,
    output logic            o_vld,
    output logic [RW/2-1:0] o_root [LANES],
    output logic [SBW-1:0]  o_sb
);
    localparam int HW  = RW / 2;
    localparam int RMW = HW + 2;

    logic [RW-1:0]  s_rad  [HW][LANES];
    logic [RMW-1:0] s_rem  [HW][LANES];
    logic [HW-1:0]  s_root [HW+1][LANES];
    logic           s_vld  [HW+1];
    logic [SBW-1:0] s_sb   [HW+1];

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            s_rad[0][l]  = i_rad[l];
            s_rem[0][l]  = '0;
            s_root[0][l] = '0;
        end
    end
    assign s_vld[0] = i_vld;
    assign s_sb[0]  = i_sb;

    for (genvar j = 0; j < HW; j++) begin : g_stage
        logic [RMW-1:0] n_rem  [LANES];
        logic [HW-1:0]  n_root [LANES];
        logic [HW-1:0]  r_root [LANES];
        logic           r_vld;
        logic [SBW-1:0] r_sb;

        always_comb begin
            logic [RMW-1:0] trial;
            logic [RMW-1:0] test;
            for (int l = 0; l < LANES; l++) begin
                trial = {s_rem[j][l][RMW-3:0], s_rad[j][l][RW-1 -: 2]};
                test  = {s_root[j][l], 2'b01};
                if (trial >= test) begin
                    n_rem[l]  = trial - test;
                    n_root[l] = {s_root[j][l][HW-2:0], 1'b1};
                end else begin
                    n_rem[l]  = trial;
                    n_root[l] = {s_root[j][l][HW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= s_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root <= n_root;
                r_sb   <= s_sb[j];
            end
        end

        assign s_root[j+1] = r_root;
        assign s_vld[j+1]  = r_vld;
        assign s_sb[j+1]   = r_sb;

        if (j < HW-1) begin : g_carry
            logic [RW-1:0]  r_rad [LANES];
            logic [RMW-1:0] r_rem [LANES];

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    for (int l = 0; l < LANES; l++) begin
                        r_rad[l] <= s_rad[j][l] << 2;
                    end
                    r_rem <= n_rem;
                end
            end

            assign s_rad[j+1] = r_rad;
            assign s_rem[j+1] = r_rem;
        end
    end

    assign o_root = s_root[HW];
    assign o_vld  = s_vld[HW];
    assign o_sb   = s_sb[HW];

endmodule

FILE: sv/rmq_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_div
// Pipelined restoring divider, one quotient bit per stage, shared divisor.
// ----------------------------------------------------------------------------
module rmq_div #(
    parameter int NUMW  = 32,
    parameter int DW    = 16,
    parameter int QW    = 15,
    parameter int LANES = 1,
    parameter int SBW   = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  logic [NUMW-1:0] i_num [LANES],
    input  logic [DW-1:0]   i_den,
    input  logic [SBW-1:0]  i_sb,
    output logic            o_vld,
    output logic [QW-1:0]   o_quo [LANES],
    output logic [SBW-1:0]  o_sb
);
    logic [DW-1:0]  s_rem [QW][LANES];
    logic [QW-1:0]  s_nl  [QW][LANES];
    logic [DW-1:0]  s_den [QW];
    logic [QW-1:0]  s_quo [QW+1][LANES];
    logic           s_vld [QW+1];
    logic [SBW-1:0] s_sb  [QW+1];

    // quotient is known to fit QW bits, so the upper numerator part starts as remainder
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            s_rem[0][l] = DW'(i_num[l][NUMW-1:QW]);
            s_nl[0][l]  = i_num[l][QW-1:0];
            s_quo[0][l] = '0;
        end
    end
    assign s_den[0] = i_den;
    assign s_vld[0] = i_vld;
    assign s_sb[0]  = i_sb;

    for (genvar j = 0; j < QW; j++) begin : g_stage
        logic [DW-1:0]  n_rem [LANES];
        logic [QW-1:0]  n_quo [LANES];
        logic [QW-1:0]  r_quo [LANES];
        logic           r_vld;
        logic [SBW-1:0] r_sb;

        always_comb begin
            logic [DW:0] trial;
            for (int l = 0; l < LANES; l++) begin
                trial = {s_rem[j][l], s_nl[j][l][QW-1]};
                if (trial >= {1'b0, s_den[j]}) begin
                    n_rem[l] = DW'(trial - {1'b0, s_den[j]});
                    n_quo[l] = {s_quo[j][l][QW-2:0], 1'b1};
                end else begin
                    n_rem[l] = DW'(trial);
                    n_quo[l] = {s_quo[j][l][QW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= s_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo <= n_quo;
                r_sb  <= s_sb[j];
            end
        end

        assign s_quo[j+1] = r_quo;
        assign s_vld[j+1] = r_vld;
        assign s_sb[j+1]  = r_sb;

        if (j < QW-1) begin : g_carry
            logic [DW-1:0] r_rem [LANES];
            logic [QW-1:0] r_nl  [LANES];
            logic [DW-1:0] r_den;

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    for (int l = 0; l < LANES; l++) begin
                        r_nl[l] <= s_nl[j][l] << 1;
                    end
                    r_rem <= n_rem;
                    r_den <= s_den[j];
                end
            end

            assign s_rem[j+1] = r_rem;
            assign s_nl[j+1]  = r_nl;
            assign s_den[j+1] = r_den;
        end
    end

    assign o_quo = s_quo[QW];
    assign o_vld = s_vld[QW];
    assign o_sb  = s_sb[QW];

endmodule

FILE: sv/rmq_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_back
// Square roots, norm, normalizing divide and signed saturating output.
// ----------------------------------------------------------------------------
module rmq_back #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [rmq_pkg::N_COMP*rmq_pkg::s_width(FRAC_BITS)+rmq_pkg::N_COMP-1:0] i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output rmq_pkg::t_quat_out  o_quat
);
    localparam int QL   = rmq_pkg::N_COMP;
    localparam int SW   = rmq_pkg::s_width(FRAC_BITS);
    localparam int RW1  = rmq_pkg::rad_width(FRAC_BITS);
    localparam int AW   = RW1 / 2;
    localparam int SUMW = 2*AW + 2;
    localparam int NW   = SUMW / 2;
    localparam int NUMW = AW + FRAC_BITS + 1;
    localparam int QW   = FRAC_BITS + 1;
    localparam int OW   = rmq_pkg::OUT_W;
    localparam logic [QW-1:0] ONE = QW'(1) << FRAC_BITS;

    logic                en;
    logic [RW1-1:0]      rad1 [QL];
    logic                v1;
    logic [AW-1:0]       a1 [QL];
    logic [QL-1:0]       neg1;

    logic                r_v2;
    logic [2*AW-1:0]     r_sq [QL];
    logic [AW-1:0]       r_a2 [QL];
    logic [QL-1:0]       r_neg2;

    logic                r_v3;
    logic [SUMW-1:0]     r_sum [2];
    logic [SUMW-1:0]     sum;
    logic [AW-1:0]       r_a3 [QL];
    logic [QL-1:0]       r_neg3;

    logic [SUMW-1:0]     rad2 [1];
    logic [QL*AW+QL-1:0] sb2_in, sb2_out;
    logic                v4;
    logic [NW-1:0]       n4 [1];

    logic                r_v5;
    logic [NUMW-1:0]     r_num [QL];
    logic [NW-1:0]       r_den;
    logic [QL-1:0]       r_neg5;

    logic                v6;
    logic [QW-1:0]       q6 [QL];
    logic [QL-1:0]       neg6;

    logic                r_out_vld;
    logic signed [OW-1:0] r_out [QL];
    logic signed [OW-1:0] n_out [QL];

    // the whole back pipeline moves unless a finished word is stuck at the output
    assign en      = !r_out_vld || i_ready;
    assign o_ready = en;
    assign o_valid = r_out_vld;

    always_comb begin
        for (int i = 0; i < QL; i++) begin
            rad1[i] = RW1'({i_data[QL + i*SW +: SW], {FRAC_BITS{1'b0}}});
        end
    end

    rmq_isqrt #(.RW(RW1), .LANES(QL), .SBW(QL)) u_sqrt_comp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_valid),
        .i_rad   (rad1),
        .i_sb    (i_data[QL-1:0]),
        .o_vld   (v1),
        .o_root  (a1),
        .o_sb    (neg1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (en) begin
            r_v2 <= v1;
            r_v3 <= r_v2;
            r_v5 <= v4;
        end
    end

    // square, then sum as a registered pair tree
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < QL; i++) begin
                r_sq[i] <= a1[i] * a1[i];
            end
            r_a2   <= a1;
            r_neg2 <= neg1;
            r_sum[0] <= SUMW'(r_sq[0]) + SUMW'(r_sq[1]);
            r_sum[1] <= SUMW'(r_sq[2]) + SUMW'(r_sq[3]);
            r_a3   <= r_a2;
            r_neg3 <= r_neg2;
        end
    end

    assign sum     = r_sum[0] + r_sum[1];
    assign rad2[0] = sum;

    always_comb begin
        sb2_in[QL-1:0] = r_neg3;
        for (int i = 0; i < QL; i++) begin
            sb2_in[QL + i*AW +: AW] = r_a3[i];
        end
    end

    rmq_isqrt #(.RW(SUMW), .LANES(1), .SBW(QL*AW+QL)) u_sqrt_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_v3),
        .i_rad   (rad2),
        .i_sb    (sb2_in),
        .o_vld   (v4),
        .o_root  (n4),
        .o_sb    (sb2_out)
    );

    // numerator a * 2^F + n/2 rounds the quotient half up
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < QL; i++) begin
                r_num[i] <= (NUMW'(sb2_out[QL + i*AW +: AW]) << FRAC_BITS)
                          + NUMW'(n4[0] >> 1);
            end
            r_den  <= n4[0];
            r_neg5 <= sb2_out[QL-1:0];
        end
    end

    rmq_div #(.NUMW(NUMW), .DW(NW), .QW(QW), .LANES(QL), .SBW(QL)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_v5),
        .i_num   (r_num),
        .i_den   (r_den),
        .i_sb    (r_neg5),
        .o_vld   (v6),
        .o_quo   (q6),
        .o_sb    (neg6)
    );

    always_comb begin
        logic [QW-1:0]      mag;
        logic signed [QW:0] sv;
        for (int i = 0; i < QL; i++) begin
            mag = (q6[i] > ONE) ? ONE : q6[i];
            sv  = neg6[i] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
            n_out[i] = OW'(sv);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= v6;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_quat.quat_w = r_out[rmq_pkg::IDX_W];
    assign o_quat.quat_x = r_out[rmq_pkg::IDX_X];
    assign o_quat.quat_y = r_out[rmq_pkg::IDX_Y];
    assign o_quat.quat_z = r_out[rmq_pkg::IDX_Z];

endmodule

FILE: sv/rotation_matrix_to_quaternion_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_core
// Converts a Q2.14 rotation matrix into a normalized Q2.14 quaternion.
//
//   channel | direction | payload          | handshake
//   --------+-----------+------------------+---------------------------
//   in      | input     | i_in_data  (mat) | i_in_valid / o_in_ready
//   out     | output    | o_out_data (quat)| o_out_valid / i_out_ready
//
// One word per cycle sustained unless the output stalls. A word passes the
// front register, queue, A-stage root pipeline, square and pair-sum
// registers, N-stage norm root pipeline, numerator register, (F+1)-stage
// divider and output register (A = rad_width(F)/2, N = A+1, F = FRAC_BITS).
// Reset is synchronous and active low and clears all valid flags.
// A stalled output freezes the back pipeline; the front and queue keep
// taking words until the queue fills.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_core #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  rmq_pkg::t_mat_in   i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output rmq_pkg::t_quat_out o_out_data
);
    localparam int WW = rmq_pkg::N_COMP*rmq_pkg::s_width(FRAC_BITS) + rmq_pkg::N_COMP;

    logic          f_vld;
    logic [WW-1:0] f_data, q_data;
    logic          b_ready;
    rmq_pkg::t_stat st;

    rmq_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_mat   (i_in_data),
        .o_valid (f_vld),
        .i_ready (!st.fifo_full),
        .o_data  (f_data)
    );

    assign st.front_vld = f_vld;

    rmq_fifo #(.W(WW), .DEPTH(rmq_pkg::FIFO_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_vld),
        .i_data  (f_data),
        .i_pop   (b_ready),
        .o_data  (q_data),
        .o_full  (st.fifo_full),
        .o_empty (st.fifo_empty)
    );

    rmq_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (!st.fifo_empty),
        .o_ready (b_ready),
        .i_data  (q_data),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_quat  (o_out_data)
    );

    a_fifo_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(st.fifo_full && st.fifo_empty))
        else $error("queue reports full and empty together");

    a_front_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (st.front_vld && st.fifo_full) |-> !o_in_ready)
        else $error("input taken while front and queue are both full");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams matrices through rotation_matrix_to_quaternion_core: a directed
// table, then random matrices (near-rotations, raw noise and tie patterns).
// Every quaternion is checked against a bit-accurate fixed-point predictor.
// ----------------------------------------------------------------------------
module testbench;

    localparam int FB        = rmq_pkg::FRAC_BITS_DEF;
    localparam int N_RANDOM  = 1430;
    localparam int N_HOLD    = 100;
    localparam int N_DIRECT  = 18;
    localparam int ONE       = 1 << FB;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    rmq_pkg::t_mat_in   i_in_data;
    logic               o_out_valid;
    logic               i_out_ready;
    rmq_pkg::t_quat_out o_out_data;

    rotation_matrix_to_quaternion_core #(.FRAC_BITS(FB)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    typedef struct {
        rmq_pkg::t_mat_in   mat;
        bit                 has_quat;
        rmq_pkg::t_quat_out quat;
    } t_row;

    rmq_pkg::t_quat_out quat_queue[$];
    int        n_errors;
    bit        stim_done;
    bit        hold_off_req;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b   = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic int sign_of(input longint v);
        return (v >= 0) ? 1 : -1;
    endfunction

    function automatic rmq_pkg::t_quat_out mat_to_quat(input rmq_pkg::t_mat_in mt);
        longint             m00, m01, m02, m10, m11, m12, m20, m21, m22;
        longint             s[4];
        longint unsigned    a[4];
        int                 sg[4];
        longint unsigned    sumsq, n, mag;
        logic [15:0]        comp[4];
        int                 k;
        rmq_pkg::t_quat_out q;
        m00 = mt.m00; m01 = mt.m01; m02 = mt.m02;
        m10 = mt.m10; m11 = mt.m11; m12 = mt.m12;
        m20 = mt.m20; m21 = mt.m21; m22 = mt.m22;
        s[0] = m00 + m11 + m22 + ONE;
        s[1] = m00 - m11 - m22 + ONE;
        s[2] = -m00 + m11 - m22 + ONE;
        s[3] = -m00 - m11 + m22 + ONE;
        sumsq = 0;
        for (int i = 0; i < 4; i++) begin
            if (s[i] < 0) s[i] = 0;
            a[i]  = int_sqrt(longint'(s[i]) << FB);
            sumsq += a[i] * a[i];
            sg[i] = 1;
        end
        k = 0;
        for (int i = 1; i < 4; i++) if (s[i] > s[k]) k = i;
        case (k)
            0: begin
                sg[1] = sign_of(m21 - m12);
                sg[2] = sign_of(m02 - m20);
                sg[3] = sign_of(m10 - m01);
            end
            1: begin
                sg[0] = sign_of(m21 - m12);
                sg[2] = sign_of(m10 + m01);
                sg[3] = sign_of(m02 + m20);
            end
            2: begin
                sg[0] = sign_of(m02 - m20);
                sg[1] = sign_of(m10 + m01);
                sg[3] = sign_of(m21 + m12);
            end
            default: begin
                sg[0] = sign_of(m10 - m01);
                sg[1] = sign_of(m20 + m02);
                sg[2] = sign_of(m21 + m12);
            end
        endcase
        sg[0] = -sg[0];
        n = int_sqrt(sumsq);
        for (int i = 0; i < 4; i++) begin
            mag = 0;
            if (n != 0) mag = ((a[i] << FB) + (n >> 1)) / n;
            if (mag > ONE) mag = ONE;
            comp[i] = (sg[i] < 0) ? 16'(-longint'(mag)) : 16'(mag);
        end
        q.quat_w = comp[rmq_pkg::IDX_W];
        q.quat_x = comp[rmq_pkg::IDX_X];
        q.quat_y = comp[rmq_pkg::IDX_Y];
        q.quat_z = comp[rmq_pkg::IDX_Z];
        return q;
    endfunction

    function automatic rmq_pkg::t_mat_in random_mat();
        rmq_pkg::t_mat_in mt;
        logic [159:0]     raw;
        int               r;
        r = $urandom_range(0, 9);
        if (r < 2) begin
            raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
            mt  = raw[143:0];
        end else if (r < 7) begin
            // near-rotation: diagonal around +-1 with cross terms in [-1, 1]
            mt = '0;
            mt.m00 = 16'($urandom_range(0, 1) ? ONE : -ONE) + 16'($urandom_range(0, 4000)) - 16'd2000;
            mt.m11 = 16'($urandom_range(0, 1) ? ONE : -ONE) + 16'($urandom_range(0, 4000)) - 16'd2000;
            mt.m22 = 16'($urandom_range(0, 1) ? ONE : -ONE) + 16'($urandom_range(0, 4000)) - 16'd2000;
            mt.m01 = 16'($urandom_range(0, 2 * ONE)) - 16'(ONE);
            mt.m02 = 16'($urandom_range(0, 2 * ONE)) - 16'(ONE);
            mt.m10 = 16'($urandom_range(0, 2 * ONE)) - 16'(ONE);
            mt.m12 = 16'($urandom_range(0, 2 * ONE)) - 16'(ONE);
            mt.m20 = 16'($urandom_range(0, 2 * ONE)) - 16'(ONE);
            mt.m21 = 16'($urandom_range(0, 2 * ONE)) - 16'(ONE);
        end else begin
            // in-range Q2.14 values with ties and equal or opposite cross terms
            mt.m00 = 16'($urandom_range(0, 4 * ONE - 1));
            mt.m11 = $urandom_range(0, 1) ? mt.m00 : 16'($urandom_range(0, 4 * ONE - 1));
            mt.m22 = $urandom_range(0, 1) ? mt.m11 : 16'($urandom_range(0, 4 * ONE - 1));
            mt.m01 = 16'($urandom_range(0, 4 * ONE - 1));
            mt.m10 = $urandom_range(0, 1) ? mt.m01 : -mt.m01;
            mt.m02 = 16'($urandom_range(0, 4 * ONE - 1));
            mt.m20 = $urandom_range(0, 1) ? mt.m02 : -mt.m02;
            mt.m12 = 16'($urandom_range(0, 4 * ONE - 1));
            mt.m21 = $urandom_range(0, 1) ? mt.m12 : -mt.m12;
        end
        return mt;
    endfunction

    function automatic t_row make_row(input rmq_pkg::t_mat_in mt, input bit known,
                                      input rmq_pkg::t_quat_out q);
        t_row rw;
        rw.mat      = mt;
        rw.has_quat = known;
        rw.quat     = q;
        return rw;
    endfunction

    task automatic send_mat(input rmq_pkg::t_mat_in mt);
        i_in_valid <= 1'b1;
        i_in_data  <= mt;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic idle_cycles(input int n);
        i_in_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (quat_queue.size() != 0) @(posedge i_clk);
    endtask

    // stimulus
    initial begin
        t_row               rows[N_DIRECT];
        rmq_pkg::t_mat_in   mt;
        rmq_pkg::t_quat_out q;
        int                 burst;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_data    = '0;
        stim_done    = 1'b0;
        hold_off_req = 1'b0;
        n_errors     = 0;

        // identity gives w = -1, vector zero
        mt = '0; mt.m00 = ONE; mt.m11 = ONE; mt.m22 = ONE;
        rows[0] = make_row(mt, 1, '{quat_w: -16'(ONE), quat_x: 0, quat_y: 0, quat_z: 0});
        // 180 deg about x
        mt = '0; mt.m00 = ONE; mt.m11 = -ONE; mt.m22 = -ONE;
        rows[1] = make_row(mt, 1, '{quat_w: 0, quat_x: 16'(ONE), quat_y: 0, quat_z: 0});
        // 180 deg about y, z
        mt = '0; mt.m00 = -ONE; mt.m11 = ONE; mt.m22 = -ONE;
        rows[2] = make_row(mt, 1, '{quat_w: 0, quat_x: 0, quat_y: 16'(ONE), quat_z: 0});
        mt = '0; mt.m00 = -ONE; mt.m11 = -ONE; mt.m22 = ONE;
        rows[3] = make_row(mt, 1, '{quat_w: 0, quat_x: 0, quat_y: 0, quat_z: 16'(ONE)});
        // all zero: four-way tie goes to w
        rows[4] = make_row('0, 0, '0);
        // all ones bits (-1 lsb), all min, all max
        rows[5] = make_row({9{16'hFFFF}}, 0, '0);
        rows[6] = make_row({9{16'h8000}}, 0, '0);
        rows[7] = make_row({9{16'h7FFF}}, 0, '0);
        // alternating bit patterns
        rows[8] = make_row({9{16'hAAAA}}, 0, '0);
        rows[9] = make_row({9{16'h5555}}, 0, '0);
        // 90 deg about z, about x, about y
        mt = '0; mt.m01 = -ONE; mt.m10 = ONE; mt.m22 = ONE;
        rows[10] = make_row(mt, 0, '0);
        mt = '0; mt.m00 = ONE; mt.m12 = -ONE; mt.m21 = ONE;
        rows[11] = make_row(mt, 0, '0);
        mt = '0; mt.m02 = ONE; mt.m11 = ONE; mt.m20 = -ONE;
        rows[12] = make_row(mt, 0, '0);
        // each non-w leader with small off-diagonals, m12 and m21 positive, the rest negative
        mt = '0; mt.m00 = ONE; mt.m11 = -ONE; mt.m22 = -ONE;
        mt.m01 = -100; mt.m10 = -100; mt.m02 = -50; mt.m20 = -70; mt.m12 = 30; mt.m21 = 10;
        rows[13] = make_row(mt, 0, '0);
        mt.m00 = -ONE; mt.m11 = ONE;
        rows[14] = make_row(mt, 0, '0);
        mt.m11 = -ONE; mt.m22 = ONE;
        rows[15] = make_row(mt, 0, '0);
        // three-way tie between w, x and y leaders, zero differences
        mt = '0; mt.m00 = ONE; mt.m11 = ONE; mt.m22 = -ONE;
        rows[16] = make_row(mt, 0, '0);
        mt = '0; mt.m00 = 16'h7FFF; mt.m11 = 16'h8000; mt.m22 = 16'h8000;
        rows[17] = make_row(mt, 0, '0);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[r]) begin
            q = mat_to_quat(rows[r].mat);
            if (rows[r].has_quat && q != rows[r].quat)
                $error("directed row %0d: predictor %h disagrees with table %h",
                       r, q, rows[r].quat);
            quat_queue.push_back(rows[r].has_quat ? rows[r].quat : q);
            send_mat(rows[r].mat);
        end
        // pause until every expected word has come
        wait_drained();

        // long receiver hold-off while the sender keeps pushing
        hold_off_req <= 1'b1;
        for (int i = 0; i < N_HOLD; i++) begin
            mt = random_mat();
            quat_queue.push_back(mat_to_quat(mt));
            send_mat(mt);
        end
        hold_off_req <= 1'b0;

        for (int i = 0; i < N_RANDOM - N_HOLD;) begin
            burst = $urandom_range(1, 40);
            for (int j = 0; j < burst && i < N_RANDOM - N_HOLD; j++, i++) begin
                mt = random_mat();
                quat_queue.push_back(mat_to_quat(mt));
                send_mat(mt);
            end
            if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 8));
        end
        i_in_valid <= 1'b0;
        stim_done  <= 1'b1;
    end

    // receiver: own stall pattern plus one long hold-off
    initial begin
        int mode;
        bit held;
        i_out_ready = 1'b0;
        held        = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_off_req && !held) begin
                held = 1'b1;
                i_out_ready <= 1'b0;
                repeat (300) @(posedge i_clk);
            end
            mode = $urandom_range(0, 99);
            if (mode < 40)      i_out_ready <= 1'b1;
            else if (mode < 80) i_out_ready <= ($urandom_range(0, 2) != 0);
            else                i_out_ready <= ($urandom_range(0, 3) == 0);
        end
    end

    // check each accepted quaternion word against the oldest prediction
    always @(posedge i_clk) begin
        rmq_pkg::t_quat_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (quat_queue.size() == 0) begin
                $error("quaternion word with none pending: %h", o_out_data);
                n_errors++;
            end else begin
                want = quat_queue.pop_front();
                if (o_out_data.quat_w !== want.quat_w) begin
                    $error("quat_w: expected %0d, actual %0d", want.quat_w, o_out_data.quat_w);
                    n_errors++;
                end
                if (o_out_data.quat_x !== want.quat_x) begin
                    $error("quat_x: expected %0d, actual %0d", want.quat_x, o_out_data.quat_x);
                    n_errors++;
                end
                if (o_out_data.quat_y !== want.quat_y) begin
                    $error("quat_y: expected %0d, actual %0d", want.quat_y, o_out_data.quat_y);
                    n_errors++;
                end
                if (o_out_data.quat_z !== want.quat_z) begin
                    $error("quat_z: expected %0d, actual %0d", want.quat_z, o_out_data.quat_z);
                    n_errors++;
                end
            end
        end
    end

    // end of run
    initial begin
        @(posedge stim_done);
        while (quat_queue.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (n_errors == 0 && quat_queue.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: rotation_matrix_to_quaternion_core.f
sv/rmq_pkg.sv
sv/rmq_front.sv
sv/rmq_fifo.sv
sv/rmq_isqrt.sv
sv/rmq_div.sv
sv/rmq_back.sv
sv/rotation_matrix_to_quaternion_core.sv
bench/testbench.sv
